### hdl/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants for the matrix multiply-accumulate block
// Holds opcodes, register indexes, controller states and the command and
// configuration structs that pass between the modules.
// ----------------------------------------------------------------------------
package mma_pkg;

	// fixed field widths
	localparam int IDX_W      = 6;
	localparam int VAL_W      = 32;
	localparam int ELEM_W     = 16;
	localparam int DIM_W      = 3;
	localparam int SIZE_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;

	// cycles between the last multiply issue and the first read-out
	localparam int DRAIN_CYCLES = 2;

	// saturation bounds in Q16.16
	localparam logic [VAL_W-1:0] ACC_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] ACC_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_LOAD_C = 2'd2,
		OP_RUN    = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_OUT       = 3'd0,
		REG_INNER_SIZE     = 3'd1,
		REG_COLS_OUT       = 3'd2,
		REG_TRANSPOSE_MODE = 3'd3,
		REG_ACCUMULATE     = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_MAC   = 2'd1,
		ST_DRAIN = 2'd2,
		ST_EMIT  = 2'd3
	} state_t;

	// clamped sizes, each stored minus one, with the transpose and accumulate flags
	typedef struct packed {
		logic [DIM_W-1:0] l_m1;
		logic [DIM_W-1:0] m_m1;
		logic [DIM_W-1:0] n_m1;
		logic             ta;
		logic             tb;
		logic             acc_mode;
	} cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic             load;
		logic             mac;
		logic             first;
		logic             last_j;
		logic             emit;
		logic             last_elem;
		logic             clear_sat;
		logic [DIM_W-1:0] i;
		logic [DIM_W-1:0] j;
		logic [DIM_W-1:0] k;
	} cmd_t;

endpackage

### hdl/mma_cfg.sv
// ----------------------------------------------------------------------------
// mma_cfg: configuration registers
// Holds the size, transpose and accumulate registers and presents the sizes
// clamped to 1..MAX_DIM.
// ----------------------------------------------------------------------------
module mma_cfg #(
	parameter int MAX_DIM = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mma_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [mma_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output mma_pkg::cfg_t                    cfg
);

	localparam logic [mma_pkg::SIZE_W-1:0] SIZE_MAX  = mma_pkg::SIZE_W'(MAX_DIM);
	localparam logic [mma_pkg::SIZE_W-1:0] SIZE_RST  = 4'd8;

	logic [mma_pkg::SIZE_W-1:0] rows_q;
	logic [mma_pkg::SIZE_W-1:0] inner_q;
	logic [mma_pkg::SIZE_W-1:0] cols_q;
	logic [1:0]                 tmode_q;
	logic                       accum_q;

	// size clamp, result minus one
	function automatic logic [mma_pkg::DIM_W-1:0] clamp_m1(input logic [mma_pkg::SIZE_W-1:0] d);
		logic [mma_pkg::SIZE_W-1:0] c;
		c = d;
		if (d == '0)
			c = mma_pkg::SIZE_W'(1);
		else if (d > SIZE_MAX)
			c = SIZE_MAX;
		return mma_pkg::DIM_W'(c - mma_pkg::SIZE_W'(1));
	endfunction

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= SIZE_RST;
			inner_q <= SIZE_RST;
			cols_q  <= SIZE_RST;
			tmode_q <= '0;
			accum_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (mma_pkg::cfg_reg_t'(cfg_addr))
				mma_pkg::REG_ROWS_OUT:       rows_q  <= cfg_wdata;
				mma_pkg::REG_INNER_SIZE:     inner_q <= cfg_wdata;
				mma_pkg::REG_COLS_OUT:       cols_q  <= cfg_wdata;
				mma_pkg::REG_TRANSPOSE_MODE: tmode_q <= cfg_wdata[1:0];
				mma_pkg::REG_ACCUMULATE:     accum_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// clamped view
	always_comb begin
		cfg.l_m1     = clamp_m1(rows_q);
		cfg.m_m1     = clamp_m1(inner_q);
		cfg.n_m1     = clamp_m1(cols_q);
		cfg.ta       = tmode_q[0];
		cfg.tb       = tmode_q[1];
		cfg.acc_mode = accum_q;
	end

endmodule

### hdl/mma_ctrl.sv
// ----------------------------------------------------------------------------
// mma_ctrl: run sequencer
// Walks i, k and j over the multiply-accumulate phase, waits for the
// pipeline to drain, then walks i and k again to read out the results.
// ----------------------------------------------------------------------------
module mma_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           opcode,
	input  mma_pkg::cfg_t        cfg,
	output logic                 busy,
	output mma_pkg::cmd_t        cmd
);

	mma_pkg::state_t            state_q, state_d;
	logic [mma_pkg::DIM_W-1:0]  i_q, j_q, k_q;
	logic                       drain_q;
	logic                       accept, is_run;
	logic                       j_end, k_end, i_end;
	logic                       drain_end;

	assign is_run    = mma_pkg::op_t'(opcode) == mma_pkg::OP_RUN;
	assign accept    = start && (state_q == mma_pkg::ST_IDLE);
	assign j_end     = j_q == cfg.m_m1;
	assign k_end     = k_q == cfg.n_m1;
	assign i_end     = i_q == cfg.l_m1;
	assign drain_end = drain_q == 1'(mma_pkg::DRAIN_CYCLES - 1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mma_pkg::ST_IDLE:  if (accept && is_run) state_d = mma_pkg::ST_MAC;
			mma_pkg::ST_MAC:   if (j_end && k_end && i_end) state_d = mma_pkg::ST_DRAIN;
			mma_pkg::ST_DRAIN: if (drain_end) state_d = mma_pkg::ST_EMIT;
			mma_pkg::ST_EMIT:  if (k_end && i_end) state_d = mma_pkg::ST_IDLE;
			default:           state_d = mma_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy          = state_q != mma_pkg::ST_IDLE;
		cmd.load      = accept && !is_run;
		cmd.clear_sat = accept && is_run;
		cmd.mac       = state_q == mma_pkg::ST_MAC;
		cmd.emit      = state_q == mma_pkg::ST_EMIT;
		cmd.first     = j_q == '0;
		cmd.last_j    = j_end;
		cmd.last_elem = k_end && i_end;
		cmd.i         = i_q;
		cmd.j         = j_q;
		cmd.k         = k_q;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mma_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			drain_q <= 1'b0;
		end else begin
			unique case (state_q)
				mma_pkg::ST_IDLE: begin
					i_q     <= '0;
					j_q     <= '0;
					k_q     <= '0;
					drain_q <= 1'b0;
				end
				mma_pkg::ST_MAC: begin
					if (!j_end) begin
						j_q <= j_q + 1'b1;
					end else begin
						j_q <= '0;
						if (!k_end) begin
							k_q <= k_q + 1'b1;
						end else begin
							k_q <= '0;
							i_q <= i_end ? '0 : i_q + 1'b1;
						end
					end
				end
				mma_pkg::ST_DRAIN: begin
					drain_q <= drain_end ? 1'b0 : drain_q + 1'b1;
				end
				mma_pkg::ST_EMIT: begin
					if (!k_end) begin
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						i_q <= i_end ? '0 : i_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### hdl/mma_dp.sv
// ----------------------------------------------------------------------------
// mma_dp: element stores and multiply-accumulate datapath
// A, B and C stores with registered reads, one 16x16 multiplier, a saturating
// 32-bit accumulator and the result output registers.
// ----------------------------------------------------------------------------
module mma_dp #(
	parameter int MAX_DIM = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mma_pkg::cfg_t                     cfg,
	input  mma_pkg::cmd_t                     cmd,
	input  logic [1:0]                        opcode,
	input  logic [mma_pkg::IDX_W-1:0]         index,
	input  logic signed [mma_pkg::VAL_W-1:0]  value,
	output logic                              result_strobe,
	output logic [mma_pkg::DIM_W-1:0]         row,
	output logic [mma_pkg::DIM_W-1:0]         col,
	output logic signed [mma_pkg::VAL_W-1:0]  result,
	output logic                              last,
	output logic                              saturated
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);

	// stores
	logic [mma_pkg::ELEM_W-1:0] a_mem [0:DEPTH-1];
	logic [mma_pkg::ELEM_W-1:0] b_mem [0:DEPTH-1];
	logic [mma_pkg::VAL_W-1:0]  c_mem [0:DEPTH-1];
	logic [DEPTH-1:0]           c_vld_q;

	logic                       idx_ok;
	logic [ADDR_W-1:0]          ld_addr;
	logic [ADDR_W-1:0]          l_sz, m_sz, n_sz;
	logic [ADDR_W-1:0]          ii, jj, kk;
	logic [ADDR_W-1:0]          a_addr, b_addr, c_addr;

	// pipeline stage 1
	logic signed [mma_pkg::ELEM_W-1:0] a_s1, b_s1;
	logic [mma_pkg::VAL_W-1:0]         crd_s1;
	logic                              cvld_s1;
	logic                              mac_s1, first_s1, lastj_s1, use_base_s1;
	logic [ADDR_W-1:0]                 caddr_s1;

	// pipeline stage 2
	logic signed [mma_pkg::VAL_W-1:0]  prod_s2;
	logic [mma_pkg::VAL_W-1:0]         base_s2;
	logic                              mac_s2, first_s2, lastj_s2;
	logic [ADDR_W-1:0]                 caddr_s2;

	logic [mma_pkg::VAL_W-1:0]         acc_q;
	logic                              sat_q;
	logic [mma_pkg::VAL_W-1:0]         addend;
	logic [mma_pkg::VAL_W:0]           sum;
	logic                              ovf;
	logic [mma_pkg::VAL_W-1:0]         acc_next;

	logic                              c_we;
	logic [ADDR_W-1:0]                 c_waddr;
	logic [mma_pkg::VAL_W-1:0]         c_wdata;

	// load index check and address
	assign idx_ok  = {1'b0, index} < (mma_pkg::IDX_W + 1)'(DEPTH);
	assign ld_addr = ADDR_W'(index);

	// operand addresses from the loop indexes
	always_comb begin
		l_sz   = ADDR_W'(cfg.l_m1) + ADDR_W'(1);
		m_sz   = ADDR_W'(cfg.m_m1) + ADDR_W'(1);
		n_sz   = ADDR_W'(cfg.n_m1) + ADDR_W'(1);
		ii     = ADDR_W'(cmd.i);
		jj     = ADDR_W'(cmd.j);
		kk     = ADDR_W'(cmd.k);
		a_addr = cfg.ta ? ADDR_W'(jj * l_sz + ii) : ADDR_W'(ii * m_sz + jj);
		b_addr = cfg.tb ? ADDR_W'(kk * m_sz + jj) : ADDR_W'(jj * n_sz + kk);
		c_addr = ADDR_W'(ii * n_sz + kk);
	end

	// A and B stores
	always_ff @(posedge clk) begin
		if (cmd.load && idx_ok && mma_pkg::op_t'(opcode) == mma_pkg::OP_LOAD_A)
			a_mem[ld_addr] <= value[mma_pkg::ELEM_W-1:0];
		if (cmd.load && idx_ok && mma_pkg::op_t'(opcode) == mma_pkg::OP_LOAD_B)
			b_mem[ld_addr] <= value[mma_pkg::ELEM_W-1:0];
		a_s1 <= a_mem[a_addr];
		b_s1 <= b_mem[b_addr];
	end

	// saturating accumulate
	always_comb begin
		addend   = first_s2 ? base_s2 : acc_q;
		sum      = {addend[mma_pkg::VAL_W-1], addend} + {prod_s2[mma_pkg::VAL_W-1], prod_s2};
		ovf      = sum[mma_pkg::VAL_W] != sum[mma_pkg::VAL_W-1];
		acc_next = ovf ? (sum[mma_pkg::VAL_W] ? mma_pkg::ACC_MIN : mma_pkg::ACC_MAX)
			: sum[mma_pkg::VAL_W-1:0];
	end

	// C store write port: run write-back or load
	always_comb begin
		c_we    = 1'b0;
		c_waddr = ld_addr;
		c_wdata = value;
		priority if (mac_s2 && lastj_s2) begin
			c_we    = 1'b1;
			c_waddr = caddr_s2;
			c_wdata = acc_next;
		end else if (cmd.load && idx_ok && mma_pkg::op_t'(opcode) == mma_pkg::OP_LOAD_C) begin
			c_we = 1'b1;
		end
	end

	// C store
	always_ff @(posedge clk) begin
		if (c_we)
			c_mem[c_waddr] <= c_wdata;
		crd_s1 <= c_mem[c_addr];
	end

	// C entry valid bits, unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_vld_q <= '0;
			cvld_s1 <= 1'b0;
		end else begin
			if (c_we)
				c_vld_q[c_waddr] <= 1'b1;
			cvld_s1 <= c_vld_q[c_addr];
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
			mac_s2 <= 1'b0;
		end else begin
			mac_s1 <= cmd.mac;
			mac_s2 <= mac_s1;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		first_s1    <= cmd.first;
		lastj_s1    <= cmd.last_j;
		caddr_s1    <= c_addr;
		use_base_s1 <= cfg.acc_mode;
		prod_s2     <= a_s1 * b_s1;
		base_s2     <= (use_base_s1 && cvld_s1) ? crd_s1 : '0;
		first_s2    <= first_s1;
		lastj_s2    <= lastj_s1;
		caddr_s2    <= caddr_s1;
		if (mac_s2)
			acc_q <= acc_next;
	end

	// sticky saturation flag, cleared when a run starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sat_q <= 1'b0;
		else if (cmd.clear_sat)
			sat_q <= 1'b0;
		else if (mac_s2 && ovf)
			sat_q <= 1'b1;
	end

	// result output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_strobe <= 1'b0;
		else
			result_strobe <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		row       <= cmd.i;
		col       <= cmd.k;
		last      <= cmd.last_elem;
		saturated <= sat_q;
	end

	assign result = crd_s1;

endmodule

### hdl/matrix_multiply_accumulate_top.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_top: C = op(A) x op(B), or C += op(A) x op(B)
// Q8.8 operands, saturating Q16.16 accumulation, optional transposes.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. Opcodes load
//   one element of A, B or C at a flat row-major index (busy stays low,
//   indexes of MAX_DIM*MAX_DIM and up are dropped) or start a run.
//   A run raises busy for a multiply-accumulate phase, one multiply-accumulate
//   per cycle through the single multiplier and the one read port of each
//   store, a drain of the multiply pipeline, then one C element per cycle.
//   Results appear in row-major order, one per cycle with result_strobe high;
//   last marks the final element and saturated reports whether any addition
//   of this run clipped. The receiver cannot stall; results are produced
//   back to back. Configuration is written through cfg_wr_en / cfg_addr /
//   cfg_wdata only while the block is idle; the user must keep to this, as
//   the block does not enforce it. Reset restores sizes 8x8x8, no transpose,
//   plain mode, and marks every C entry as zero; A and B hold nothing until
//   loaded. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_top #(
	parameter int MAX_DIM = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        opcode,
	input  logic [mma_pkg::IDX_W-1:0]         index,
	input  logic signed [mma_pkg::VAL_W-1:0]  value,
	input  logic                              cfg_wr_en,
	input  logic [mma_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [mma_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output logic                              result_strobe,
	output logic [mma_pkg::DIM_W-1:0]         row,
	output logic [mma_pkg::DIM_W-1:0]         col,
	output logic signed [mma_pkg::VAL_W-1:0]  result,
	output logic                              last,
	output logic                              saturated
);

	mma_pkg::cfg_t cfg;
	mma_pkg::cmd_t cmd;

	// configuration registers
	mma_cfg #(
		.MAX_DIM (MAX_DIM)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// run sequencer
	mma_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.cfg    (cfg),
		.busy   (busy),
		.cmd    (cmd)
	);

	// stores and arithmetic
	mma_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.opcode        (opcode),
		.index         (index),
		.value         (value),
		.result_strobe (result_strobe),
		.row           (row),
		.col           (col),
		.result        (result),
		.last          (last),
		.saturated     (saturated)
	);

endmodule
